// File: sv/u8sc_pkg.sv
// Shared types and constants for the UTF-8 string compare block.
// Used by every module of the block; depends on nothing.
package u8sc_pkg;

    localparam int CountWidth = 16;
    localparam int CodeWidth = 21;

    localparam logic [1:0] VERDICT_UNDECIDED = 2'd0;
    localparam logic [1:0] VERDICT_EQUAL = 2'd1;
    localparam logic [1:0] VERDICT_LESS = 2'd2;
    localparam logic [1:0] VERDICT_GREATER = 2'd3;

    localparam logic [0:0] REG_CASE_SENSITIVE = 1'd0;
    localparam logic [0:0] REG_MAX_CHARACTERS = 1'd1;

    localparam logic [7:0] CONT_MASK = 8'h3F;
    localparam logic [CodeWidth-1:0] UPPER_FIRST = 21'd65;
    localparam logic [CodeWidth-1:0] UPPER_LAST = 21'd90;
    localparam logic [CodeWidth-1:0] FOLD_OFFSET = 21'd32;

    // One classified character pair, handed from the front to the back.
    typedef struct packed {
        logic       src_end;   // zero source lead or no source bytes left
        logic       src_trunc; // source character longer than the bytes left
        logic       ref_has;   // reference still has a character
        logic [1:0] cmp;       // code point compare result as a verdict code
    } u8sc_item_t;

endpackage

// File: sv/u8sc_front.sv
// Front part: decodes both characters of an item, folds case unless case_sensitive is set, and compares.
// Depends on u8sc_pkg.
module u8sc_front
(
    input  logic [31:0]         reference_char,
    input  logic                reference_has_char,
    input  logic [31:0]         source_char,
    input  logic [15:0]         source_bytes_left,
    input  logic                case_sensitive,
    output u8sc_pkg::u8sc_item_t item
);

    function automatic logic [2:0] lead_length(input logic [7:0] lead);
        logic [2:0] len;
        if (lead < 8'hC0)
            len = 3'd1;
        else if (lead < 8'hE0)
            len = 3'd2;
        else if (lead < 8'hF0)
            len = 3'd3;
        else
            len = 3'd4;
        return len;
    endfunction

    function automatic logic [u8sc_pkg::CodeWidth-1:0] decode(input logic [31:0] word);
        logic [7:0] lead;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [u8sc_pkg::CodeWidth-1:0] cp;
        lead = word[31:24];
        b1 = word[23:16] & u8sc_pkg::CONT_MASK;
        b2 = word[15:8] & u8sc_pkg::CONT_MASK;
        b3 = word[7:0] & u8sc_pkg::CONT_MASK;
        case (lead_length(lead))
            3'd1:    cp = {13'd0, lead};
            3'd2:    cp = {10'd0, lead[4:0], b1[5:0]};
            3'd3:    cp = {5'd0, lead[3:0], b1[5:0], b2[5:0]};
            default: cp = {lead[2:0], b1[5:0], b2[5:0], b3[5:0]};
        endcase
        return cp;
    endfunction

    function automatic logic [u8sc_pkg::CodeWidth-1:0] fold(
        input logic [u8sc_pkg::CodeWidth-1:0] cp
    );
        logic [u8sc_pkg::CodeWidth-1:0] res;
        if (cp >= u8sc_pkg::UPPER_FIRST && cp <= u8sc_pkg::UPPER_LAST)
            res = cp + u8sc_pkg::FOLD_OFFSET;
        else
            res = cp;
        return res;
    endfunction

    logic [u8sc_pkg::CodeWidth-1:0] ref_cp;
    logic [u8sc_pkg::CodeWidth-1:0] src_cp;

    always_comb
    begin
        ref_cp = decode(reference_char);
        src_cp = decode(source_char);
        if (!case_sensitive)
        begin
            ref_cp = fold(ref_cp);
            src_cp = fold(src_cp);
        end
        item.src_end = (source_bytes_left == 16'd0) || (source_char[31:24] == 8'd0);
        item.src_trunc = {13'd0, lead_length(source_char[31:24])} > source_bytes_left;
        item.ref_has = reference_has_char;
        if (ref_cp > src_cp)
            item.cmp = u8sc_pkg::VERDICT_LESS;
        else if (ref_cp < src_cp)
            item.cmp = u8sc_pkg::VERDICT_GREATER;
        else
            item.cmp = u8sc_pkg::VERDICT_UNDECIDED;
    end

endmodule

// File: sv/u8sc_queue.sv
// Two-entry queue of classified items between the front and the back.
// Depends on u8sc_pkg.
module u8sc_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  u8sc_pkg::u8sc_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output u8sc_pkg::u8sc_item_t head_item
);

    u8sc_pkg::u8sc_item_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("item pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("item popped from an empty queue");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with the fill count");

endmodule

// File: sv/u8sc_back.sv
// Back part: keeps the character counter, settles the verdict of each item
// and holds it in the output register. Depends on u8sc_pkg.
module u8sc_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  u8sc_pkg::u8sc_item_t head_item,
    output logic                 pop,
    input  logic [15:0]          max_characters,
    output logic                 out_valid,
    output logic [1:0]           out_verdict,
    input  logic                 out_ready
);

    logic [u8sc_pkg::CountWidth-1:0] count_reg;
    logic [u8sc_pkg::CountWidth-1:0] count_next;
    logic                            out_valid_reg;
    logic [1:0]                      verdict_reg;
    logic [1:0]                      verdict_next;
    logic                            at_limit;

    assign pop = head_valid && (!out_valid_reg || out_ready);
    assign at_limit = (count_reg == max_characters);
    assign out_valid = out_valid_reg;
    assign out_verdict = verdict_reg;

    always_comb
    begin
        if (head_item.src_end || (!at_limit && head_item.src_trunc))
            verdict_next = head_item.ref_has ? u8sc_pkg::VERDICT_LESS
                                             : u8sc_pkg::VERDICT_EQUAL;
        else if (at_limit)
            verdict_next = u8sc_pkg::VERDICT_EQUAL;
        else if (!head_item.ref_has)
            verdict_next = u8sc_pkg::VERDICT_GREATER;
        else
            verdict_next = head_item.cmp;
        // Only a matching character pair keeps the compare going.
        if (verdict_next == u8sc_pkg::VERDICT_UNDECIDED)
            count_next = count_reg + 16'd1;
        else
            count_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                count_reg <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            verdict_reg <= verdict_next;
    end

    a_clear_on_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && verdict_next != u8sc_pkg::VERDICT_UNDECIDED) |=> (count_reg == '0))
        else $error("character counter not cleared after a verdict");

    a_count_on_match: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && verdict_next == u8sc_pkg::VERDICT_UNDECIDED)
            |=> (count_reg == $past(count_reg) + 16'd1))
        else $error("character counter did not advance on a match");

    a_result_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (out_valid_reg && verdict_reg == $past(verdict_next)))
        else $error("popped item did not reach the output register");

endmodule

// File: sv/utf8_string_compare.sv
// UTF-8 string compare: one character pair enters per item and one verdict
// item leaves for each. The block sustains one item per clock while the output
// is not stalled; a verdict reaches the output after its item has been written
// into the queue and the back part has registered its verdict, and a two-entry
// queue lets input and output stall independently.
// Configuration is an APB port: case_sensitive at 0x0, max_characters at 0x4.
module utf8_string_compare
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    // [31:0] reference_char, [63:32] source_char, [79:64] source_bytes_left
    input  logic [79:0] s_tdata,
    // [0] reference_has_char
    input  logic        s_tuser,
    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] verdict, [7:2] zero
    output logic [7:0]  m_tdata
);

    logic                 case_sensitive_reg;
    logic [15:0]          max_characters_reg;
    logic                 cfg_write;
    u8sc_pkg::u8sc_item_t front_item;
    u8sc_pkg::u8sc_item_t head_item;
    logic                 queue_full;
    logic                 head_valid;
    logic                 pop;
    logic                 push;
    logic [1:0]           verdict;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            case_sensitive_reg <= 1'b0;
            max_characters_reg <= 16'hFFFF;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                u8sc_pkg::REG_CASE_SENSITIVE: case_sensitive_reg <= pwdata[0];
                u8sc_pkg::REG_MAX_CHARACTERS: max_characters_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            u8sc_pkg::REG_CASE_SENSITIVE: prdata = {31'd0, case_sensitive_reg};
            u8sc_pkg::REG_MAX_CHARACTERS: prdata = {16'd0, max_characters_reg};
            default:                      prdata = 32'd0;
        endcase
    end

    assign s_tready = !queue_full;
    assign push = s_tvalid && !queue_full;

    u8sc_front u_front
    (
        .reference_char     (s_tdata[31:0]),
        .reference_has_char (s_tuser),
        .source_char        (s_tdata[63:32]),
        .source_bytes_left  (s_tdata[79:64]),
        .case_sensitive     (case_sensitive_reg),
        .item               (front_item)
    );

    u8sc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (front_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    u8sc_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head_item      (head_item),
        .pop            (pop),
        .max_characters (max_characters_reg),
        .out_valid      (m_tvalid),
        .out_verdict    (verdict),
        .out_ready      (m_tready)
    );

    assign m_tdata = {6'd0, verdict};

endmodule

// File: tb/tb_utf8_string_compare.sv
// Self-checking testbench for the UTF-8 string compare block.
// Streams character pairs through the block and checks every verdict against
// a cycle-free predictor; needs only u8sc_pkg and utf8_string_compare.
`timescale 1ns / 1ps

module tb_utf8_string_compare;

    typedef struct {
        logic [31:0] ref_word;
        logic        ref_has;
        logic [31:0] src_word;
        logic [15:0] bytes_left;
    } char_pair_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = 80'd0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    // Predictor state and its copy of the registers.
    logic                            case_exact = 1'b0;
    logic [15:0]                     max_chars = 16'hFFFF;
    logic [u8sc_pkg::CountWidth-1:0] chars_matched = '0;

    char_pair_t pending_pairs[$];
    logic [1:0] expected_verdicts[$];
    char_pair_t tx_pair;
    logic [1:0] rx_want;
    int         tx_gap = 0;
    int         rx_gap = 0;
    logic       tx_calm = 1'b0;
    logic       rx_calm = 1'b0;
    logic       rx_hold = 1'b0;
    int         n_pushed = 0;
    int         n_accepted = 0;
    int         n_checked = 0;
    int         err_count = 0;

    utf8_string_compare u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 clk = ~clk;

    function automatic logic [2:0] char_len(input logic [7:0] lead);
        if (lead < 8'hC0)
            return 3'd1;
        if (lead < 8'hE0)
            return 3'd2;
        if (lead < 8'hF0)
            return 3'd3;
        return 3'd4;
    endfunction

    // Continuation bytes contribute only their low six bits; bytes past the
    // character's length are ignored.
    function automatic logic [u8sc_pkg::CodeWidth-1:0] code_point(input logic [31:0] word);
        logic [u8sc_pkg::CodeWidth-1:0] cp;
        case (char_len(word[31:24]))
            3'd1: cp = {13'd0, word[31:24]};
            3'd2: cp = {10'd0, word[28:24], word[21:16]};
            3'd3: cp = {5'd0, word[27:24], word[21:16], word[13:8]};
            default: cp = {word[26:24], word[21:16], word[13:8], word[5:0]};
        endcase
        return cp;
    endfunction

    function automatic logic [u8sc_pkg::CodeWidth-1:0] fold_case(
        input logic [u8sc_pkg::CodeWidth-1:0] cp
    );
        if (!case_exact && cp >= u8sc_pkg::UPPER_FIRST && cp <= u8sc_pkg::UPPER_LAST)
            return cp + u8sc_pkg::FOLD_OFFSET;
        return cp;
    endfunction

    function automatic logic [1:0] next_verdict(input logic [31:0] ref_word,
                                                input logic ref_has,
                                                input logic [31:0] src_word,
                                                input logic [15:0] bytes_left);
        logic [1:0]                     v;
        logic [u8sc_pkg::CodeWidth-1:0] cp_ref;
        logic [u8sc_pkg::CodeWidth-1:0] cp_src;
        logic                           at_limit;
        at_limit = (chars_matched == max_chars);
        // A truncated source character only ends the compare below the limit.
        if (bytes_left == 16'd0 || src_word[31:24] == 8'h00 ||
            (!at_limit && 16'(char_len(src_word[31:24])) > bytes_left))
            v = ref_has ? u8sc_pkg::VERDICT_LESS : u8sc_pkg::VERDICT_EQUAL;
        else if (at_limit)
            v = u8sc_pkg::VERDICT_EQUAL;
        else
        begin
            chars_matched = chars_matched + 1'b1;
            if (!ref_has)
                v = u8sc_pkg::VERDICT_GREATER;
            else
            begin
                cp_ref = fold_case(code_point(ref_word));
                cp_src = fold_case(code_point(src_word));
                if (cp_ref > cp_src)
                    v = u8sc_pkg::VERDICT_LESS;
                else if (cp_ref < cp_src)
                    v = u8sc_pkg::VERDICT_GREATER;
                else
                    v = u8sc_pkg::VERDICT_UNDECIDED;
            end
        end
        if (v != u8sc_pkg::VERDICT_UNDECIDED)
            chars_matched = '0;
        return v;
    endfunction

    function automatic int pick_gap(input logic calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Random character with random filler in the bytes it does not use.
    function automatic logic [31:0] rand_char();
        logic [31:0] w;
        w = $urandom();
        case ($urandom_range(0, 9))
            0, 1: w[31:24] = 8'h41 + 8'($urandom_range(0, 25));
            2, 3: w[31:24] = 8'h61 + 8'($urandom_range(0, 25));
            4: w[31:24] = 8'($urandom_range(1, 127));
            5: w[31:24] = 8'hC0 | 8'($urandom_range(0, 31));
            6: w[31:24] = 8'hE0 | 8'($urandom_range(0, 15));
            7: w[31:24] = 8'hF0 | 8'($urandom_range(0, 15));
            8: w[31:24] = 8'h80 | 8'($urandom_range(0, 63));
            default: ;
        endcase
        return w;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        err_count++;
    endtask

    task automatic push_pair(input logic [31:0] ref_word, input logic ref_has,
                             input logic [31:0] src_word, input logic [15:0] bytes_left);
        char_pair_t p;
        p.ref_word = ref_word;
        p.ref_has = ref_has;
        p.src_word = src_word;
        p.bytes_left = bytes_left;
        pending_pairs.push_back(p);
        n_pushed++;
    endtask

    // One compare: n matching character positions, then one of several
    // endings (mismatch, source exhausted, reference ended, truncated source,
    // zero source lead, or no ending so the count carries on).
    task automatic queue_string(input int n);
        logic [31:0] refs[$];
        logic [31:0] srcs[$];
        logic [31:0] r;
        logic [31:0] s;
        int          remaining;
        int          ending;
        int          i;
        ending = $urandom_range(0, 5);
        remaining = 0;
        for (i = 0; i < n; i++)
        begin
            r = rand_char();
            s = r;
            case (char_len(s[31:24]))
                3'd1: s[23:0] = 24'($urandom());
                3'd2: s[15:0] = 16'($urandom());
                3'd3: s[7:0] = 8'($urandom());
                default: ;
            endcase
            s[23:22] = 2'($urandom());
            if (((s[31:24] >= 8'h41 && s[31:24] <= 8'h5A) ||
                 (s[31:24] >= 8'h61 && s[31:24] <= 8'h7A)) && $urandom_range(0, 2) == 0)
                s[29] = ~s[29];
            if (ending == 0 && i == n - 1)
                s = rand_char();
            refs.push_back(r);
            srcs.push_back(s);
            remaining += char_len(s[31:24]);
        end
        for (i = 0; i < n; i++)
        begin
            push_pair(refs[i], 1'b1, srcs[i],
                      16'(remaining + ($urandom_range(0, 3) == 0 ? $urandom_range(1, 300) : 0)));
            remaining -= char_len(srcs[i][31:24]);
        end
        case (ending)
            1: push_pair(rand_char(), 1'($urandom_range(0, 1)), rand_char(), 16'd0);
            2:
            begin
                s = rand_char();
                push_pair($urandom(), 1'b0, s, 16'(char_len(s[31:24]) + $urandom_range(0, 5)));
            end
            3:
            begin
                s = rand_char();
                s[31:24] = 8'hE0 | 8'($urandom_range(0, 31));
                push_pair(rand_char(), 1'($urandom_range(0, 1)), s, 16'($urandom_range(1, 2)));
            end
            4:
            begin
                s = $urandom();
                s[31:24] = 8'h00;
                push_pair(rand_char(), 1'($urandom_range(0, 1)), s, 16'($urandom_range(1, 65535)));
            end
            default: ;
        endcase
    endtask

    task automatic write_register(input logic [0:0] index, input logic [15:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (index == u8sc_pkg::REG_CASE_SENSITIVE)
            case_exact = value[0];
        else
            max_chars = value;
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (n_checked != n_pushed);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(input logic exact, input logic [15:0] limit,
                             input int budget, input logic calm);
        int start;
        write_register(u8sc_pkg::REG_CASE_SENSITIVE, {15'd0, exact});
        write_register(u8sc_pkg::REG_MAX_CHARACTERS, limit);
        tx_calm <= calm;
        rx_calm <= calm;
        start = n_pushed;
        while (n_pushed - start < budget)
        begin
            if ($urandom_range(0, 9) < 8)
                queue_string($urandom_range(1, 12));
            else
                push_pair($urandom(), 1'($urandom_range(0, 1)), $urandom(),
                          $urandom_range(0, 1) ? 16'($urandom()) : 16'($urandom_range(0, 8)));
        end
        wait_idle();
        tx_calm <= 1'b0;
        rx_calm <= 1'b0;
    endtask

    // Sender: holds an item until it is taken, then waits a random gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= 80'd0;
            s_tuser <= 1'b0;
            tx_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_verdicts.push_back(next_verdict(s_tdata[31:0], s_tuser,
                                                         s_tdata[63:32], s_tdata[79:64]));
                n_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_pairs.size() > 0)
                begin
                    tx_pair = pending_pairs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {tx_pair.bytes_left, tx_pair.src_word, tx_pair.ref_word};
                    s_tuser <= tx_pair.ref_has;
                    tx_gap = pick_gap(tx_calm);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver ready pattern.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_gap = 0;
        end
        else if (rx_gap > 0)
        begin
            rx_gap--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= !rx_hold;
            rx_gap = pick_gap(rx_calm);
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_verdicts.size() == 0)
                report_mismatch($sformatf("verdict %0d arrived with none expected",
                                          m_tdata[1:0]));
            else
            begin
                rx_want = expected_verdicts.pop_front();
                n_checked++;
                if (m_tdata[1:0] !== rx_want)
                    report_mismatch($sformatf("item %0d: verdict %0d, expected %0d",
                                              n_checked, m_tdata[1:0], rx_want));
            end
        end
    end

    // Long receiver hold-off while the sender keeps offering items.
    initial
    begin
        wait (n_accepted >= 500);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (300) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin
        #1_500_000;
        $display("utf8_string_compare verification failed");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed items under the reset settings: folding on, limit 0xFFFF.
        push_pair(32'h0000_0000, 1'b0, 32'h0000_0000, 16'h0000);
        push_pair(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
        push_pair(32'h4100_0000, 1'b1, 32'h61FF_FFFF, 16'd10);
        push_pair(32'hC280_0000, 1'b1, 32'h8000_0000, 16'd9);
        push_pair(32'hF48F_BFBF, 1'b1, 32'hF48F_BFBF, 16'd8);
        push_pair(32'hC3A9_FFFF, 1'b1, 32'hC3E9_0000, 16'd4);
        push_pair(32'hE282_AC00, 1'b1, 32'hE282_AD00, 16'd3);
        push_pair(32'h7A00_0000, 1'b1, 32'h6100_0000, 16'd1);
        push_pair(32'h5A00_0000, 1'b1, 32'h5B00_0000, 16'd1);
        push_pair(32'h6100_0000, 1'b0, 32'h6100_0000, 16'd5);
        push_pair(32'h6100_0000, 1'b1, 32'hE282_AC00, 16'd2);
        push_pair(32'h6100_0000, 1'b0, 32'hF09F_9880, 16'd3);
        push_pair(32'h6100_0000, 1'b1, 32'h0012_3456, 16'd7);
        push_pair(32'h0000_0000, 1'b1, 32'h0100_0000, 16'd1);
        push_pair(32'hF880_8080, 1'b1, 32'hF880_8081, 16'd4);
        push_pair(32'h8000_0000, 1'b1, 32'hC280_0000, 16'd2);
        push_pair(32'hFFFF_FFFF, 1'b0, 32'h7F00_0000, 16'h0000);
        push_pair(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 16'h0000);
        wait_idle();

        run_phase(1'b1, 16'hFFFF, 180, 1'b0);
        run_phase(1'b0, 16'd0, 180, 1'b0);
        run_phase(1'b1, 16'd1, 180, 1'b1);
        run_phase(1'b0, 16'd4, 180, 1'b0);
        run_phase(1'b1, 16'($urandom_range(2, 10)), 180, 1'b0);
        run_phase(1'b0, 16'hFFFF, 180, 1'b0);

        repeat (20) @(posedge clk);
        if (expected_verdicts.size() != 0)
            report_mismatch($sformatf("%0d expected verdicts never arrived",
                                      expected_verdicts.size()));
        if (err_count == 0)
            $display("utf8_string_compare verification clean");
        else
            $display("utf8_string_compare verification failed");
        $finish;
    end

endmodule
